>>> hdl/crec_pkg.sv
// Package for the circle / rectangle edge contact block.
// Holds field widths, register and zone codes, and the item and stage structs.
// No dependencies.
package crec_pkg;

	// Field widths.
	localparam int COORD_BITS  = 16;
	localparam int HALF_BITS   = 14;
	localparam int RADIUS_BITS = 12;
	localparam int ZONE_BITS   = 4;

	// Rectangle edge coordinates (center plus or minus half size) and distances to them.
	localparam int EDGE_BITS = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS + 1) + 1;
	localparam int DIFF_BITS = EDGE_BITS + 1;
	localparam int SQ_BITS   = 2 * RADIUS_BITS;

	// Configuration port.
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
	localparam logic [REG_IDX_BITS-1:0] REG_BALL_RADIUS = '0;
	localparam logic [RADIUS_BITS-1:0]  RADIUS_RESET    = 12'd186;

	// Zone codes and the increments used when edges combine.
	localparam logic [ZONE_BITS-1:0] ZONE_NONE      = 4'd0;
	localparam logic [ZONE_BITS-1:0] ZONE_BOTTOM    = 4'd1;
	localparam logic [ZONE_BITS-1:0] ZONE_TOP       = 4'd2;
	localparam logic [ZONE_BITS-1:0] ZONE_LEFT      = 4'd3;
	localparam logic [ZONE_BITS-1:0] ZONE_RIGHT     = 4'd4;
	localparam logic [ZONE_BITS-1:0] ZONE_ADD_LEFT  = 4'd4;
	localparam logic [ZONE_BITS-1:0] ZONE_ADD_RIGHT = 4'd6;

	// One input item.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] ball_x;
		logic signed [COORD_BITS-1:0] ball_y;
		logic signed [COORD_BITS-1:0] rect_cx;
		logic signed [COORD_BITS-1:0] rect_cy;
		logic [HALF_BITS-1:0]         half_width;
		logic [HALF_BITS-1:0]         half_height;
		logic                         ball_held;
	} item_t;

	// One result item.
	typedef struct packed {
		logic                 hit_bottom;
		logic                 hit_top;
		logic                 hit_left;
		logic                 hit_right;
		logic [ZONE_BITS-1:0] zone;
	} result_t;

	// Geometry flags and clamped distances handed from the geometry stage onward.
	// Suffixes b, t, l, r name the bottom, top, left and right edge lines.
	typedef struct packed {
		logic                   held;
		logic                   in_x;
		logic                   in_y;
		logic                   hw_zero;
		logic                   hh_zero;
		logic                   lt_b;
		logic                   lt_t;
		logic                   lt_l;
		logic                   lt_r;
		logic                   le_b;
		logic                   le_t;
		logic                   le_l;
		logic                   le_r;
		logic [RADIUS_BITS-1:0] d_b;
		logic [RADIUS_BITS-1:0] d_t;
		logic [RADIUS_BITS-1:0] d_l;
		logic [RADIUS_BITS-1:0] d_r;
	} geom_t;

	// Magnitude of a signed distance.
	function automatic logic [DIFF_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] v);
		logic [DIFF_BITS-1:0] m;
		m = v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
		return m;
	endfunction

endpackage

>>> hdl/crec_apb_regs.sv
// APB-style configuration register file for the edge contact block.
// Holds the ball radius register. Depends on crec_pkg.
module crec_apb_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crec_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [crec_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [crec_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output logic [crec_pkg::RADIUS_BITS-1:0]    radius
);
	import crec_pkg::*;

	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    wr_en;
	logic [RADIUS_BITS-1:0]  radius_q;

	// Word index from the byte address; the port never waits.
	assign reg_idx = paddr[APB_ADDR_BITS-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	// Radius register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (wr_en && (reg_idx == REG_BALL_RADIUS)) begin
			radius_q <= pwdata[RADIUS_BITS-1:0];
		end
	end

	// Read back.
	always_comb begin
		unique case (reg_idx)
			REG_BALL_RADIUS: prdata = APB_DATA_BITS'(radius_q);
			default:         prdata = '0;
		endcase
	end

	assign radius = radius_q;

endmodule

>>> hdl/crec_geom.sv
// Geometry stage of the edge contact block: edge positions, distances and compares.
// Registers its flags into the second pipeline stage. Depends on crec_pkg.
module crec_geom (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  crec_pkg::item_t                  item_s1,
	input  logic [crec_pkg::RADIUS_BITS-1:0] radius,
	output logic                             valid_s2,
	output crec_pkg::geom_t                  geom_s2
);
	import crec_pkg::*;

	logic signed [EDGE_BITS-1:0] px, py, lx, rx, by, ty;
	logic signed [DIFF_BITS-1:0] dif_l, dif_r, dif_b, dif_t;
	logic [DIFF_BITS-1:0]        mag_l, mag_r, mag_b, mag_t;
	logic [DIFF_BITS-1:0]        r_ext;
	geom_t                       geom;

	// Edge lines of the rectangle and the ball center, all sign extended.
	assign px = EDGE_BITS'(item_s1.ball_x);
	assign py = EDGE_BITS'(item_s1.ball_y);
	assign lx = EDGE_BITS'(item_s1.rect_cx) - EDGE_BITS'($signed({1'b0, item_s1.half_width}));
	assign rx = EDGE_BITS'(item_s1.rect_cx) + EDGE_BITS'($signed({1'b0, item_s1.half_width}));
	assign by = EDGE_BITS'(item_s1.rect_cy) - EDGE_BITS'($signed({1'b0, item_s1.half_height}));
	assign ty = EDGE_BITS'(item_s1.rect_cy) + EDGE_BITS'($signed({1'b0, item_s1.half_height}));

	// Distances from the ball center to each edge line.
	assign dif_l = DIFF_BITS'(px) - DIFF_BITS'(lx);
	assign dif_r = DIFF_BITS'(px) - DIFF_BITS'(rx);
	assign dif_b = DIFF_BITS'(py) - DIFF_BITS'(by);
	assign dif_t = DIFF_BITS'(py) - DIFF_BITS'(ty);
	assign mag_l = mag(dif_l);
	assign mag_r = mag(dif_r);
	assign mag_b = mag(dif_b);
	assign mag_t = mag(dif_t);
	assign r_ext = DIFF_BITS'(radius);

	// Compare against the radius; distances within the radius fit its width.
	always_comb begin
		geom.held    = item_s1.ball_held;
		geom.in_x    = (px >= lx) && (px <= rx);
		geom.in_y    = (py >= by) && (py <= ty);
		geom.hw_zero = (item_s1.half_width == '0);
		geom.hh_zero = (item_s1.half_height == '0);
		geom.lt_b    = mag_b < r_ext;
		geom.lt_t    = mag_t < r_ext;
		geom.lt_l    = mag_l < r_ext;
		geom.lt_r    = mag_r < r_ext;
		geom.le_b    = mag_b <= r_ext;
		geom.le_t    = mag_t <= r_ext;
		geom.le_l    = mag_l <= r_ext;
		geom.le_r    = mag_r <= r_ext;
		geom.d_b     = geom.le_b ? mag_b[RADIUS_BITS-1:0] : '0;
		geom.d_t     = geom.le_t ? mag_t[RADIUS_BITS-1:0] : '0;
		geom.d_l     = geom.le_l ? mag_l[RADIUS_BITS-1:0] : '0;
		geom.d_r     = geom.le_r ? mag_r[RADIUS_BITS-1:0] : '0;
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			geom_s2 <= geom;
		end
	end

endmodule

>>> hdl/crec_contact.sv
// Contact stages of the edge contact block: squared corner distances, edge flags, zone.
// Produces the registered result and its strobe. Depends on crec_pkg.
module crec_contact (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s2,
	input  crec_pkg::geom_t                  geom_s2,
	input  logic [crec_pkg::RADIUS_BITS-1:0] radius,
	output logic                             done,
	output crec_pkg::result_t                result
);
	import crec_pkg::*;

	logic                 valid_s3;
	geom_t                geom_s3;
	logic [SQ_BITS-1:0]   sq_b_s3, sq_t_s3, sq_l_s3, sq_r_s3, sq_rad_s3;
	logic                 near_lb, near_rb, near_lt, near_rt;
	logic                 hb, ht, hl, hr;
	logic [ZONE_BITS-1:0] zone;
	result_t              res;
	logic                 done_q;
	result_t              result_q;

	// Squares of the clamped distances and of the radius.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			geom_s3   <= geom_s2;
			sq_b_s3   <= geom_s2.d_b * geom_s2.d_b;
			sq_t_s3   <= geom_s2.d_t * geom_s2.d_t;
			sq_l_s3   <= geom_s2.d_l * geom_s2.d_l;
			sq_r_s3   <= geom_s2.d_r * geom_s2.d_r;
			sq_rad_s3 <= radius * radius;
		end
	end

	// A corner is near when both offsets are within the radius and the squares sum within it.
	assign near_lb = geom_s3.le_l && geom_s3.le_b &&
		(({1'b0, sq_l_s3} + {1'b0, sq_b_s3}) <= {1'b0, sq_rad_s3});
	assign near_rb = geom_s3.le_r && geom_s3.le_b &&
		(({1'b0, sq_r_s3} + {1'b0, sq_b_s3}) <= {1'b0, sq_rad_s3});
	assign near_lt = geom_s3.le_l && geom_s3.le_t &&
		(({1'b0, sq_l_s3} + {1'b0, sq_t_s3}) <= {1'b0, sq_rad_s3});
	assign near_rt = geom_s3.le_r && geom_s3.le_t &&
		(({1'b0, sq_r_s3} + {1'b0, sq_t_s3}) <= {1'b0, sq_rad_s3});

	// Edge flags: line close, and the center over the segment or an end near.
	assign hb = !geom_s3.held && !geom_s3.hw_zero && geom_s3.lt_b &&
		(geom_s3.in_x || near_lb || near_rb);
	assign ht = !geom_s3.held && !geom_s3.hw_zero && geom_s3.lt_t &&
		(geom_s3.in_x || near_lt || near_rt);
	assign hl = !geom_s3.held && !geom_s3.hh_zero && geom_s3.lt_l &&
		(geom_s3.in_y || near_lb || near_lt);
	assign hr = !geom_s3.held && !geom_s3.hh_zero && geom_s3.lt_r &&
		(geom_s3.in_y || near_rb || near_rt);

	// Zone code: top overrides bottom, left and right add on when combined.
	always_comb begin
		zone = ZONE_NONE;
		if (hb) begin
			zone = ZONE_BOTTOM;
		end
		if (ht) begin
			zone = ZONE_TOP;
		end
		if (hl) begin
			zone = (zone == ZONE_NONE) ? ZONE_LEFT : zone + ZONE_ADD_LEFT;
		end
		if (hr) begin
			zone = (zone == ZONE_NONE) ? ZONE_RIGHT : zone + ZONE_ADD_RIGHT;
		end
		res.hit_bottom = hb;
		res.hit_top    = ht;
		res.hit_left   = hl;
		res.hit_right  = hr;
		res.zone       = zone;
	end

	// Result register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			result_q <= res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	// A held ball never reports contact.
	a_held_no_contact: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && geom_s3.held |=> result.zone == ZONE_NONE && !result.hit_bottom &&
			!result.hit_top && !result.hit_left && !result.hit_right)
		else $error("held ball produced a contact");

	// The zone is empty exactly when no edge is touched.
	a_zone_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.zone == ZONE_NONE) == !(result.hit_bottom || result.hit_top ||
			result.hit_left || result.hit_right)))
		else $error("zone disagrees with edge flags");
`endif

endmodule

>>> hdl/circle_rectangle_edge_contact.sv
// Top level of the circle / rectangle edge contact block.
// Instantiates crec_apb_regs, crec_geom and crec_contact. Depends on crec_pkg.

// The block takes one item in every clock cycle: busy is always low, so an item is
// accepted at each edge where start is high. Each item's result appears on result,
// marked by done for exactly one cycle, and must be taken at the edge that ends that
// cycle because the block has no way to hold it. Each item passes the input
// register, the geometry stage (edge positions, distances and compares), the
// squaring stage, and the result register in that order; results come out in the
// order the items went in. The ball radius is set through the APB port at byte
// address 0 and should be changed only while no item is in flight.
module circle_rectangle_edge_contact (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  crec_pkg::item_t                     item,
	output logic                                done,
	output crec_pkg::result_t                   result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crec_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [crec_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [crec_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready
);
	import crec_pkg::*;

	logic [RADIUS_BITS-1:0] ball_radius;
	logic                   accept;
	logic                   valid_s1;
	item_t                  item_s1;
	logic                   valid_s2;
	geom_t                  geom_s2;

	// The pipeline never stalls.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers.
	crec_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.radius  (ball_radius)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Geometry stage.
	crec_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.radius   (ball_radius),
		.valid_s2 (valid_s2),
		.geom_s2  (geom_s2)
	);

	// Squaring and decision stages.
	crec_contact u_contact (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.geom_s2  (geom_s2),
		.radius   (ball_radius),
		.done     (done),
		.result   (result)
	);

`ifndef NO_ASSERTIONS
	// Every strobe traces back to an accepted item.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result strobe without an accepted item");

	// Every item accepted out of reset yields a strobe.
	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept, 4) && $past(arst_n, 4) && $past(arst_n, 3) && $past(arst_n, 2) &&
			$past(arst_n, 1) |-> done)
		else $error("accepted item produced no result");
`endif

endmodule
